>>> sv/wrle_pkg.sv
package wrle_pkg;

    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 8;
    localparam int TOTAL_W    = 13;
    localparam int TAG_W      = 12;
    localparam int POP_W      = 7;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_TDATA_W = 104;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'h1FFF;

    // register index taken from the word address
    localparam logic REG_ROW_NUMBER = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic                 row_done;
        logic [TAG_W-1:0]     row_tag;
        logic [TOTAL_W-1:0]   set_bits_total;
        logic [WORD_W-1:0]    run_word;
        logic [COUNT_W-1:0]   run_count;
    } run_result_t;

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

    function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] w);
        logic [4:0] h0, h1, h2, h3;
        h0 = {1'b0, pop8(w[7:0])}   + {1'b0, pop8(w[15:8])};
        h1 = {1'b0, pop8(w[23:16])} + {1'b0, pop8(w[31:24])};
        h2 = {1'b0, pop8(w[39:32])} + {1'b0, pop8(w[47:40])};
        h3 = {1'b0, pop8(w[55:48])} + {1'b0, pop8(w[63:56])};
        return ({2'b00, h0} + {2'b00, h1}) + ({2'b00, h2} + {2'b00, h3});
    endfunction

endpackage

>>> sv/word_run_length_encoder_top.sv
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+---------------------------------------------
// s_*       | in        | tvalid / tready  | tdata: data_word, tlast: last_word
// m_*       | out       | tvalid / tready  | tdata: run_count, run_word, set_bits_total,
//           |           |                  |        row_tag; tlast: row_done
// apb       | in        | psel / penable   | row_number at byte address 0
//
// one item per cycle while s_tready is high; runs are closed in the same cycle the item is accepted
// an item that both closes a run and ends the row gives two results, which
// drain in order through the 4-entry result queue
// s_tready is low while fewer than two queue entries are free
// reset clears the open run, the row total and row_number
module word_run_length_encoder_top #(
    parameter int RUN_CAP = 254
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wrle_pkg::IN_TDATA_W-1:0]      s_tdata,   // [63:0] data_word
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] run_count, [71:8] run_word, [84:72] set_bits_total, [96:85] row_tag
    output logic [wrle_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wrle_pkg::ADDR_W-1:0]          paddr,
    input  logic [wrle_pkg::DATA_W-1:0]          pwdata,
    output logic [wrle_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import wrle_pkg::*;

    localparam int RB_W  = $clog2(64 * RUN_CAP + 1);
    localparam int SUM_W = ((RB_W > TOTAL_W) ? RB_W : TOTAL_W) + 1;

    logic [TAG_W-1:0]   row_number_reg;
    logic [WORD_W-1:0]  held_word_reg,  held_word_next;
    logic [COUNT_W-1:0] run_len_reg,    run_len_next;
    logic [RB_W-1:0]    run_bits_reg,   run_bits_next;
    logic [POP_W-1:0]   held_pop_reg,   held_pop_next;
    logic [TOTAL_W-1:0] bit_total_reg,  bit_total_next;

    run_result_t        queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg,  count_next;

    logic               accept, pop_out, cfg_write;
    logic               run_open, extend, close_run, push0, push1;
    logic [POP_W-1:0]   in_pop, pop1;
    logic [COUNT_W-1:0] len1;
    logic [RB_W-1:0]    bits1;
    logic [WORD_W-1:0]  word1;
    logic [TOTAL_W-1:0] total0, total1, mid_total;
    logic [SUM_W-1:0]   sum0, sum1;
    run_result_t        res0, res1;

    // apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ROW_NUMBER)
                       ? {{(DATA_W-TAG_W){1'b0}}, row_number_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_number_reg <= '0;
        end
        else if (cfg_write && paddr[2] == REG_ROW_NUMBER)
        begin
            row_number_reg <= pwdata[TAG_W-1:0];
        end
    end

    // handshakes
    assign s_tready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop_out  = m_tvalid && m_tready;
    assign m_tdata  = {{(OUT_TDATA_W-97){1'b0}},
                       queue_reg[rd_ptr_reg].row_tag,
                       queue_reg[rd_ptr_reg].set_bits_total,
                       queue_reg[rd_ptr_reg].run_word,
                       queue_reg[rd_ptr_reg].run_count};
    assign m_tlast  = queue_reg[rd_ptr_reg].row_done;

    // run tracking
    always_comb
    begin
        in_pop    = pop64(s_tdata);
        run_open  = (run_len_reg != '0);
        extend    = run_open && (s_tdata == held_word_reg)
                    && (run_len_reg < COUNT_W'(RUN_CAP));
        close_run = run_open && !extend;

        sum0   = SUM_W'(bit_total_reg) + SUM_W'(run_bits_reg);
        total0 = (sum0 > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum0[TOTAL_W-1:0];

        if (extend)
        begin
            len1      = run_len_reg + COUNT_W'(1);
            bits1     = run_bits_reg + RB_W'(held_pop_reg);
            word1     = held_word_reg;
            pop1      = held_pop_reg;
            mid_total = bit_total_reg;
        end
        else
        begin
            len1      = COUNT_W'(1);
            bits1     = RB_W'(in_pop);
            word1     = s_tdata;
            pop1      = in_pop;
            mid_total = close_run ? total0 : bit_total_reg;
        end

        sum1   = SUM_W'(mid_total) + SUM_W'(bits1);
        total1 = (sum1 > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum1[TOTAL_W-1:0];

        res0.run_count      = run_len_reg;
        res0.run_word       = held_word_reg;
        res0.set_bits_total = total0;
        res0.row_tag        = row_number_reg;
        res0.row_done       = 1'b0;

        res1.run_count      = len1;
        res1.run_word       = word1;
        res1.set_bits_total = total1;
        res1.row_tag        = row_number_reg;
        res1.row_done       = 1'b1;

        push0 = accept && close_run;
        push1 = accept && s_tlast;

        held_word_next = held_word_reg;
        run_len_next   = run_len_reg;
        run_bits_next  = run_bits_reg;
        held_pop_next  = held_pop_reg;
        bit_total_next = bit_total_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                held_word_next = '0;
                run_len_next   = '0;
                run_bits_next  = '0;
                held_pop_next  = '0;
                bit_total_next = '0;
            end
            else
            begin
                held_word_next = word1;
                run_len_next   = len1;
                run_bits_next  = bits1;
                held_pop_next  = pop1;
                bit_total_next = mid_total;
            end
        end

        wr_ptr_next = wr_ptr_reg + QPTR_W'(push0) + QPTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop_out);
        count_next  = count_reg + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_word_reg <= '0;
            run_len_reg   <= '0;
            run_bits_reg  <= '0;
            held_pop_reg  <= '0;
            bit_total_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            held_word_reg <= held_word_next;
            run_len_reg   <= run_len_next;
            run_bits_reg  <= run_bits_next;
            held_pop_reg  <= held_pop_next;
            bit_total_reg <= bit_total_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(push0)] <= res1;
        end
    end

endmodule

>>> bench/word_run_length_encoder_top_tb.sv
`timescale 1ns / 100ps

module word_run_length_encoder_top_tb;

    import wrle_pkg::*;

    localparam int RUN_CAP      = 254;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    run_result_t expected_runs[$];
    logic [WORD_W-1:0] open_word;
    int                open_len;
    int                row_bits;
    logic [TAG_W-1:0]  row_tag_reg;
    int                mismatches;
    int                stall_left;
    int                quiet_cycles;
    bit                idle_on;

    word_run_length_encoder_top #(
        .RUN_CAP (RUN_CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void close_run(input logic done);
        run_result_t r;
        int          sum;
        sum = row_bits + $countones(open_word) * open_len;
        if (sum > int'(TOTAL_MAX))
        begin
            sum = int'(TOTAL_MAX);
        end
        row_bits         = sum;
        r.run_count      = open_len[COUNT_W-1:0];
        r.run_word       = open_word;
        r.set_bits_total = sum[TOTAL_W-1:0];
        r.row_tag        = row_tag_reg;
        r.row_done       = done;
        expected_runs.insert(expected_runs.size(), r);
    endfunction

    function automatic void predict_runs(input logic [WORD_W-1:0] word, input logic last);
        if (open_len == 0)
        begin
            open_word = word;
            open_len  = 1;
        end
        else if (word == open_word && open_len < RUN_CAP)
        begin
            open_len++;
        end
        else
        begin
            close_run(1'b0);
            open_word = word;
            open_len  = 1;
        end
        if (last)
        begin
            close_run(1'b1);
            open_word = '0;
            open_len  = 0;
            row_bits  = 0;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] seen);
        if (seen !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatches++;
        end
    endfunction

    function automatic void check_run();
        run_result_t want;
        if (expected_runs.size() == 0)
        begin
            $error("unexpected run item: tdata 0x%0h tlast %0b", m_tdata, m_tlast);
            mismatches++;
        end
        else
        begin
            want = expected_runs.pop_front();
            compare_field("run_count", 64'(want.run_count), 64'(m_tdata[7:0]));
            compare_field("run_word", want.run_word, m_tdata[71:8]);
            compare_field("set_bits_total", 64'(want.set_bits_total), 64'(m_tdata[84:72]));
            compare_field("row_tag", 64'(want.row_tag), 64'(m_tdata[96:85]));
            compare_field("tdata_pad", '0, 64'(m_tdata[OUT_TDATA_W-1:97]));
            compare_field("row_done", 64'(want.row_done), 64'(m_tlast));
        end
    endfunction

    // result side: check each item, then, when idle_on is set, hold tready low for a random stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_run();
                stall_left = idle_on ? $urandom_range(0, 8) : 0;
                m_tready <= (stall_left == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                begin
                    m_tready <= 1'b1;
                end
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
        else
        begin
            m_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(input logic [WORD_W-1:0] word, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_runs(word, last);
    endtask

    task automatic wait_idle(input int hold_off);
        s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (hold_off) @(posedge clk);
    endtask

    task automatic write_row_number(input logic [TAG_W-1:0] value);
        wait_idle(DRAIN_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROW_NUMBER, 2'b00};
        pwdata  <= {{(DATA_W-TAG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        row_tag_reg = value;
    endtask

    function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] prev);
        logic [WORD_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return prev;
            4:          return '0;
            5:          return '1;
            6:          return one_hot;
            7:          return ~one_hot;
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_row_number();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return TAG_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic test_directed();
        idle_on = 1'b1;
        write_row_number(12'hFFF);
        // single-word rows
        send_item(64'h0, 1'b1);
        send_item('1, 1'b1);
        // last item closes a run and flushes its own
        send_item(64'h5555_5555_5555_5555, 1'b0);
        send_item(64'h5555_5555_5555_5555, 1'b0);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'h1, 1'b0);
        wait_idle(0);
        send_item(64'h1, 1'b0);
        send_item(64'h1, 1'b1);
        send_item(64'h0123_4567_89AB_CDEF, 1'b0);
        send_item(64'hFEDC_BA98_7654_3210, 1'b0);
        send_item(64'hFEDC_BA98_7654_3210, 1'b1);
        send_item('1, 1'b0);
        send_item('1, 1'b0);
        send_item(64'h0, 1'b0);
        send_item(64'h0, 1'b1);
    endtask

    task automatic test_run_cap();
        logic [WORD_W-1:0] word;
        write_row_number(12'h000);
        idle_on = 1'b0;
        // cap reached with all ones, which also saturates the total
        repeat (255) send_item('1, 1'b0);
        send_item('1, 1'b1);
        word = {$urandom, $urandom};
        for (int k = 0; k < RUN_CAP; k++)
        begin
            send_item(word, k == RUN_CAP - 1);
        end
    endtask

    task automatic test_random_rows();
        int                sent;
        int                row_len;
        logic [WORD_W-1:0] word;
        sent = 0;
        word = '0;
        write_row_number(pick_row_number());
        while (sent < 220)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
            begin
                write_row_number(pick_row_number());
            end
            row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < row_len; k++)
            begin
                if (sent == 100 || $urandom_range(0, 59) == 0)
                begin
                    wait_idle(0);
                end
                word = next_word(word);
                send_item(word, k == row_len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        open_word    = '0;
        open_len     = 0;
        row_bits     = 0;
        row_tag_reg  = '0;
        mismatches   = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_run_cap();
        test_random_rows();

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0 && expected_runs.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
